@@ hdl/tsa_pkg.sv @@
`timescale 1ns / 1ps
package tsa_pkg;

  localparam int MAX_WORDS = 128;
  localparam int WORD_BITS = 32;

  localparam int CFG_W  = 8;
  localparam int SIZE_W = $clog2(MAX_WORDS + 1);
  localparam int ADDR_W = $clog2(MAX_WORDS);
  localparam int LCNT_W = $clog2(MAX_WORDS / 2 + 1);
  localparam int UCNT_W = $clog2(MAX_WORDS - MAX_WORDS / 2 + 1);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic SEL_LOWER = 1'b0;
  localparam logic SEL_UPPER = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic               cmd;
    logic               stack_select;
    logic signed [31:0] push_value;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
  } out_t;

  typedef struct packed {
    logic [1:0]        status;
    logic              wr;
    logic              rd;
    logic [ADDR_W-1:0] addr;
    word_t             word;
  } op_t;

  function automatic word_t to_word(logic [31:0] v);
    return WORD_BITS'(v);
  endfunction

  function automatic logic signed [31:0] from_word(word_t w);
    logic signed [WORD_BITS-1:0] ws;
    ws = w;
    return 32'(ws);
  endfunction

endpackage

@@ hdl/tsa_front.sv @@
`timescale 1ns / 1ps
module tsa_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  tsa_pkg::in_t             in_word,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [tsa_pkg::CFG_W-1:0] cfg_data,
  input  logic                     q_full,
  output logic                     q_push,
  output tsa_pkg::op_t             q_data
);

  logic [tsa_pkg::SIZE_W-1:0] size;
  logic [tsa_pkg::SIZE_W-1:0] size_next;
  logic [tsa_pkg::LCNT_W-1:0] lcnt;
  logic [tsa_pkg::LCNT_W-1:0] lcnt_next;
  logic [tsa_pkg::UCNT_W-1:0] ucnt;
  logic [tsa_pkg::UCNT_W-1:0] ucnt_next;
  logic [tsa_pkg::SIZE_W-1:0] lcap;
  logic [tsa_pkg::SIZE_W-1:0] ucap;
  logic [tsa_pkg::SIZE_W-1:0] lcnt_x;
  logic [tsa_pkg::SIZE_W-1:0] ucnt_x;
  logic                       acc;
  logic                       cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign full      = q_full;
  assign acc       = push && !q_full;
  assign q_push    = acc;

  assign lcap   = size >> 1;
  assign ucap   = size - lcap;
  assign lcnt_x = tsa_pkg::SIZE_W'(lcnt);
  assign ucnt_x = tsa_pkg::SIZE_W'(ucnt);

  always_comb begin
    if (int'(cfg_data) == 0) begin
      size_next = tsa_pkg::SIZE_W'(1);
    end else if (int'(cfg_data) > tsa_pkg::MAX_WORDS) begin
      size_next = tsa_pkg::SIZE_W'(tsa_pkg::MAX_WORDS);
    end else begin
      size_next = tsa_pkg::SIZE_W'(cfg_data);
    end
  end

  always_comb begin
    q_data.status = tsa_pkg::ST_OK;
    q_data.wr     = 1'b0;
    q_data.rd     = 1'b0;
    q_data.addr   = '0;
    q_data.word   = tsa_pkg::to_word(in_word.push_value);
    lcnt_next     = lcnt;
    ucnt_next     = ucnt;
    case ({in_word.cmd, in_word.stack_select})
      {tsa_pkg::CMD_PUSH, tsa_pkg::SEL_LOWER}: begin
        if (lcnt_x >= lcap) begin
          q_data.status = tsa_pkg::ST_OVERFLOW;
        end else begin
          q_data.wr   = 1'b1;
          q_data.addr = tsa_pkg::ADDR_W'(lcnt_x);
          lcnt_next   = tsa_pkg::LCNT_W'(lcnt_x + 1'b1);
        end
      end
      {tsa_pkg::CMD_PUSH, tsa_pkg::SEL_UPPER}: begin
        if (ucnt_x >= ucap) begin
          q_data.status = tsa_pkg::ST_OVERFLOW;
        end else begin
          q_data.wr   = 1'b1;
          q_data.addr = tsa_pkg::ADDR_W'(size - 1'b1 - ucnt_x);
          ucnt_next   = tsa_pkg::UCNT_W'(ucnt_x + 1'b1);
        end
      end
      {tsa_pkg::CMD_POP, tsa_pkg::SEL_LOWER}: begin
        if (lcnt_x == '0) begin
          q_data.status = tsa_pkg::ST_UNDERFLOW;
        end else begin
          q_data.rd   = 1'b1;
          q_data.addr = tsa_pkg::ADDR_W'(lcnt_x - 1'b1);
          lcnt_next   = tsa_pkg::LCNT_W'(lcnt_x - 1'b1);
        end
      end
      default: begin
        if (ucnt_x == '0) begin
          q_data.status = tsa_pkg::ST_UNDERFLOW;
        end else begin
          q_data.rd   = 1'b1;
          q_data.addr = tsa_pkg::ADDR_W'(size - ucnt_x);
          ucnt_next   = tsa_pkg::UCNT_W'(ucnt_x - 1'b1);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size <= tsa_pkg::SIZE_W'(tsa_pkg::MAX_WORDS);
      lcnt <= '0;
      ucnt <= '0;
    end else if (cfg_wr) begin
      size <= size_next;
      lcnt <= '0;
      ucnt <= '0;
    end else if (acc) begin
      lcnt <= lcnt_next;
      ucnt <= ucnt_next;
    end
  end

endmodule

@@ hdl/tsa_cmd_q.sv @@
`timescale 1ns / 1ps
module tsa_cmd_q (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tsa_pkg::op_t wdata,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output tsa_pkg::op_t rdata
);

  tsa_pkg::op_t ent [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = cnt == 2'd2;
  assign empty   = cnt == 2'd0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = ent[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      if (do_push && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) ent[wptr] <= wdata;
  end

endmodule

@@ hdl/tsa_back.sv @@
`timescale 1ns / 1ps
module tsa_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  tsa_pkg::op_t  q_data,
  output logic          q_pop,
  output logic          empty,
  input  logic          pop,
  output tsa_pkg::out_t out_word
);

  tsa_pkg::word_t mem [tsa_pkg::MAX_WORDS];
  tsa_pkg::word_t rd_word;
  logic           pend_valid;
  logic [1:0]     pend_status;
  logic           pend_rd;

  tsa_pkg::out_t  res [2];
  tsa_pkg::out_t  res_in;
  logic           wptr;
  logic           rptr;
  logic [1:0]     cnt;
  logic           res_full;
  logic           take;
  logic           move;
  logic           do_pop;

  assign res_full = cnt == 2'd2;
  assign take     = !q_empty && (!pend_valid || !res_full);
  assign move     = pend_valid && !res_full;
  assign do_pop   = pop && cnt != 2'd0;
  assign q_pop    = take;
  assign empty    = cnt == 2'd0;
  assign out_word = res[rptr];

  always_comb begin
    res_in.status    = pend_status;
    res_in.pop_value = pend_rd ? tsa_pkg::from_word(rd_word) : '0;
  end

  always_ff @(posedge clk) begin
    if (take && q_data.wr) mem[q_data.addr] <= q_data.word;
    if (take && q_data.rd) rd_word <= mem[q_data.addr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_status <= q_data.status;
      pend_rd     <= q_data.rd;
    end
    if (move) res[wptr] <= res_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      wptr       <= 1'b0;
      rptr       <= 1'b0;
      cnt        <= 2'd0;
    end else begin
      if (take) begin
        pend_valid <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
      if (move) wptr <= ~wptr;
      if (do_pop) rptr <= ~rptr;
      if (move && !do_pop) begin
        cnt <= cnt + 2'd1;
      end else if (do_pop && !move) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ hdl/two_stacks_shared_array.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake              word
// in_word   in   push / full            cmd, stack_select, push_value
// out_word  out  pop / empty            status, pop_value
// cfg_data  in   cfg_valid / cfg_ready  array_size, empties both stacks
//
// One command per cycle while full stays low; a result reaches out_word through
// the command queue, the registered memory read and the result queue.
// Synchronous reset: size 128, both stacks and both queues empty.
// full rises when the 2-entry command queue fills; a stalled result side
// backs up through the 2-entry result queue into it.
module two_stacks_shared_array (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  tsa_pkg::in_t              in_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tsa_pkg::CFG_W-1:0] cfg_data,
  output logic                      empty,
  input  logic                      pop,
  output tsa_pkg::out_t             out_word
);

  tsa_pkg::op_t f_data;
  tsa_pkg::op_t b_data;
  logic         f_push;
  logic         q_full;
  logic         q_empty;
  logic         q_pop;

  tsa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (f_push),
    .q_data    (f_data)
  );

  tsa_cmd_q u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (f_push),
    .wdata (f_data),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (b_data)
  );

  tsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (b_data),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
  );

endmodule

@@ tb/sv/two_stacks_shared_array_tb.sv @@
`timescale 1ns / 1ps
module two_stacks_shared_array_tb;
  import tsa_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_PAUSE  = 6;
  localparam int CYCLE_LIMIT  = 500000;

  class stack_scoreboard;
    word_t       words [MAX_WORDS];
    int unsigned size;
    int unsigned lower_count;
    int unsigned upper_count;
    out_t        expected_q [$];
    int          errors;
    int          accepted;
    int          checked;
    int          overflows;
    int          underflows;

    function new();
      size = MAX_WORDS;
      lower_count = 0;
      upper_count = 0;
    endfunction

    function void set_size(logic [CFG_W-1:0] v);
      int unsigned n;
      n = 32'(v);
      if (n < 1) n = 1;
      if (n > MAX_WORDS) n = MAX_WORDS;
      size = n;
      lower_count = 0;
      upper_count = 0;
    endfunction

    function void note_command(in_t w);
      out_t                        res;
      int unsigned                 lower_cap;
      int unsigned                 upper_cap;
      int unsigned                 addr;
      logic signed [WORD_BITS-1:0] ws;
      lower_cap = size / 2;
      upper_cap = size - lower_cap;
      res.status = ST_OK;
      res.pop_value = '0;
      if (w.cmd == CMD_PUSH) begin
        if (w.stack_select == SEL_LOWER) begin
          if (lower_count >= lower_cap) begin
            res.status = ST_OVERFLOW;
          end else begin
            words[lower_count] = word_t'(w.push_value);
            lower_count++;
          end
        end else begin
          if (upper_count >= upper_cap) begin
            res.status = ST_OVERFLOW;
          end else begin
            addr = size - 1 - upper_count;
            words[addr] = word_t'(w.push_value);
            upper_count++;
          end
        end
      end else begin
        if (w.stack_select == SEL_LOWER) begin
          if (lower_count == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            lower_count--;
            ws = words[lower_count];
            res.pop_value = 32'(ws);
          end
        end else begin
          if (upper_count == 0) begin
            res.status = ST_UNDERFLOW;
          end else begin
            upper_count--;
            addr = size - 1 - upper_count;
            ws = words[addr];
            res.pop_value = 32'(ws);
          end
        end
      end
      if (res.status == ST_OVERFLOW) overflows++;
      if (res.status == ST_UNDERFLOW) underflows++;
      expected_q.push_back(res);
      accepted++;
    endfunction

    function void check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected word: status %0d pop_value %0d", got.status, got.pop_value);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        errors++;
      end
      if (got.pop_value !== exp.pop_value) begin
        $error("pop_value: expected %0d, actual %0d", exp.pop_value, got.pop_value);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             push = 1'b0;
  logic             full;
  in_t              in_word = '0;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             empty;
  logic             pop = 1'b0;
  out_t             out_word;

  stack_scoreboard sb = new();

  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int          hold_left = 0;
  int          rx_gap = 0;
  int          cycles = 0;
  int          size_writes = 0;
  int unsigned phase_size [10];

  two_stacks_shared_array i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(out_word);
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      pop <= 1'b0;
    end else if (rx_idle && $urandom_range(0, 7) == 0) begin
      rx_gap <= $urandom_range(1, 18) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  function automatic in_t make_cmd(logic c, logic s, logic [31:0] v);
    in_t w;
    w.cmd = c;
    w.stack_select = s;
    w.push_value = v;
    return w;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_cmd(input in_t w);
    if (tx_idle && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_command(w);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_size(v);
    size_writes++;
  endtask

  initial begin
    int unsigned eff;
    int unsigned wave;
    int unsigned count;
    int unsigned push_pct;
    logic        fav;
    logic        sel;
    logic        c;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // size 3: lower holds 1, upper holds 2
    write_size(8'd3);
    send_cmd(make_cmd(CMD_POP, SEL_LOWER, 32'h1234_5678));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'h0));
    send_cmd(make_cmd(CMD_PUSH, SEL_LOWER, 32'h7FFF_FFFF));
    send_cmd(make_cmd(CMD_PUSH, SEL_LOWER, 32'h0000_0001));
    send_cmd(make_cmd(CMD_PUSH, SEL_UPPER, 32'h8000_0000));
    send_cmd(make_cmd(CMD_PUSH, SEL_UPPER, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_PUSH, SEL_UPPER, 32'h0000_0000));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'hAAAA_AAAA));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'h0));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'h0));
    send_cmd(make_cmd(CMD_POP, SEL_LOWER, 32'h0));
    send_cmd(make_cmd(CMD_POP, SEL_LOWER, 32'h0));

    // size 1: lower stack has no room at all
    write_size(8'd1);
    send_cmd(make_cmd(CMD_PUSH, SEL_LOWER, 32'h0000_0000));
    send_cmd(make_cmd(CMD_PUSH, SEL_UPPER, 32'h5555_5555));
    send_cmd(make_cmd(CMD_PUSH, SEL_UPPER, 32'hAAAA_AAAA));
    send_cmd(make_cmd(CMD_POP, SEL_LOWER, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'hFFFF_FFFF));
    send_cmd(make_cmd(CMD_POP, SEL_UPPER, 32'h0));

    phase_size = '{128, 1, 2, 5, 0, 255, 64, 7, 3, 0};
    phase_size[9] = $urandom_range(1, 128);

    for (int p = 0; p < 10; p++) begin
      write_size(phase_size[p][CFG_W-1:0]);
      eff = sb.size;
      wave = eff + 4;
      count = (2 * wave > 60) ? 2 * wave : 60;
      if (p == 6) hold_req <= ~hold_req;
      if (p >= 8) begin
        tx_idle = 1'b0;
        rx_idle <= 1'b0;
      end
      fav = SEL_LOWER;
      push_pct = 85;
      for (int unsigned i = 0; i < count; i++) begin
        // alternate fill and drain waves, biased toward one stack
        if (i % wave == 0) begin
          fav = 1'($urandom_range(0, 1));
          push_pct = ((i / wave) % 2 == 0) ? 85 : 15;
        end
        c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        sel = ($urandom_range(0, 99) < 80) ? fav : ~fav;
        send_cmd(make_cmd(c, sel, rand_value()));
      end
    end

    drain();
    $display("%0d commands over %0d size settings: %0d words checked, %0d overflows, %0d underflows",
             sb.accepted, size_writes, sb.checked, sb.overflows, sb.underflows);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
